FILE: rtl/vpbb_pkg.sv
// Shared types and constants of the vector path bounding box block.
`timescale 1ns / 1ps

package vpbb_pkg;

   // segment points per request and the queue between front and back
   localparam int POINTS      = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_INDEX_W = 3;

   // command index, op bits 7..1
   localparam logic [6:0] CMD_CLOSE  = 7'd0;
   localparam logic [6:0] CMD_MOVE   = 7'd1;
   localparam logic [6:0] CMD_LINE   = 7'd2;
   localparam logic [6:0] CMD_HLINE  = 7'd3;
   localparam logic [6:0] CMD_VLINE  = 7'd4;
   localparam logic [6:0] CMD_QUAD   = 7'd5;
   localparam logic [6:0] CMD_CUBIC  = 7'd6;
   localparam logic [6:0] CMD_SQUAD  = 7'd7;
   localparam logic [6:0] CMD_SCUBIC = 7'd8;
   localparam logic [6:0] CMD_LIMIT  = 7'd13;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X_FROM_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHEAR_X_FROM_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHEAR_Y_FROM_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y_FROM_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y       = 3'd5;

   localparam logic [31:0] MATRIX_ONE = 32'h0001_0000;

   typedef struct packed {
      logic signed [31:0] sxx;
      logic signed [31:0] sxy;
      logic signed [31:0] ox;
      logic signed [31:0] syx;
      logic signed [31:0] syy;
      logic signed [31:0] oy;
   } matrix_type;

   // one resolved segment on its way from front to back
   typedef struct packed {
      logic [POINTS-1:0][31:0] px;
      logic [POINTS-1:0][31:0] py;
      logic [POINTS-1:0]       mask;
      logic                    last;
      logic                    bad;
   } seg_type;

endpackage

FILE: rtl/vpbb_front.sv
// Front end: decodes the segment command and resolves its points against the current point.
`timescale 1ns / 1ps

module vpbb_front import vpbb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         op,
   input  logic signed [31:0] coord_a,
   input  logic signed [31:0] coord_b,
   input  logic signed [31:0] coord_c,
   input  logic signed [31:0] coord_d,
   input  logic signed [31:0] coord_e,
   input  logic signed [31:0] coord_f,
   input  logic               end_of_path,
   output seg_type            seg
);

   logic signed [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [31:0] sub_x_ff, sub_x_in, sub_y_ff, sub_y_in;
   logic               bad_ff, bad_in;

   logic [6:0]         kind;
   logic               rel;
   logic signed [31:0] off_x, off_y;
   logic signed [31:0] ax, ay, by, cx, dy, dx, ey, ex, fy;

   // saturating add onto the signed 32-bit range
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return s[31:0];
   endfunction

   assign kind  = op[7:1];
   assign rel   = op[0];
   assign off_x = rel ? cur_x_ff : 32'sd0;
   assign off_y = rel ? cur_y_ff : 32'sd0;

   assign ax = sat_add(coord_a, off_x);
   assign ay = sat_add(coord_a, off_y);
   assign by = sat_add(coord_b, off_y);
   assign cx = sat_add(coord_c, off_x);
   assign dy = sat_add(coord_d, off_y);
   assign dx = sat_add(coord_d, off_x);
   assign ey = sat_add(coord_e, off_y);
   assign ex = sat_add(coord_e, off_x);
   assign fy = sat_add(coord_f, off_y);

   always_comb begin
      seg      = '0;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      sub_x_in = sub_x_ff;
      sub_y_in = sub_y_ff;
      bad_in   = bad_ff;
      if (!bad_ff) begin
         if (kind >= CMD_LIMIT) begin
            bad_in = 1'b1;
         end else begin
            case (kind)
               CMD_CLOSE: begin
                  cur_x_in = sub_x_ff;
                  cur_y_in = sub_y_ff;
               end
               CMD_MOVE, CMD_LINE, CMD_SQUAD: begin
                  seg.px[0] = ax;  seg.py[0] = by;  seg.mask = 3'b001;
                  cur_x_in  = ax;  cur_y_in  = by;
                  if (kind == CMD_MOVE) begin
                     sub_x_in = ax;
                     sub_y_in = by;
                  end
               end
               CMD_HLINE: begin
                  seg.px[0] = ax;  seg.py[0] = cur_y_ff;  seg.mask = 3'b001;
                  cur_x_in  = ax;
               end
               CMD_VLINE: begin
                  seg.px[0] = cur_x_ff;  seg.py[0] = ay;  seg.mask = 3'b001;
                  cur_y_in  = ay;
               end
               CMD_QUAD, CMD_SCUBIC: begin
                  seg.px[0] = ax;  seg.py[0] = by;
                  seg.px[1] = cx;  seg.py[1] = dy;  seg.mask = 3'b011;
                  cur_x_in  = cx;  cur_y_in  = dy;
               end
               CMD_CUBIC: begin
                  seg.px[0] = ax;  seg.py[0] = by;
                  seg.px[1] = cx;  seg.py[1] = dy;
                  seg.px[2] = ex;  seg.py[2] = fy;  seg.mask = 3'b111;
                  cur_x_in  = ex;  cur_y_in  = fy;
               end
               default: begin
                  // arcs: end point only
                  seg.px[0] = dx;  seg.py[0] = ey;  seg.mask = 3'b001;
                  cur_x_in  = dx;  cur_y_in  = ey;
               end
            endcase
         end
      end
      seg.bad  = bad_in;
      seg.last = end_of_path;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_path)) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         sub_x_ff <= '0;
         sub_y_ff <= '0;
         bad_ff   <= 1'b0;
      end else if (accept) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         sub_x_ff <= sub_x_in;
         sub_y_ff <= sub_y_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

FILE: rtl/vpbb_queue.sv
// Short queue of resolved segments between front and back.
`timescale 1ns / 1ps

module vpbb_queue import vpbb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_seg,
   output logic    push_ready,
   input  logic    pop_ready,
   output logic    pop_valid,
   output seg_type head
);

   seg_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop_ready && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_seg;
      end
   end

endmodule

FILE: rtl/vpbb_back.sv
// Back end: affine transform pipeline, box accumulation and result register.
`timescale 1ns / 1ps

module vpbb_back import vpbb_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  matrix_type         mtx,
   input  logic               in_valid,
   input  seg_type            in_seg,
   output logic               in_ready,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_box_min_x,
   output logic signed [31:0] rsp_box_min_y,
   output logic signed [31:0] rsp_box_max_x,
   output logic signed [31:0] rsp_box_max_y,
   output logic               rsp_box_valid,
   output logic               rsp_status
);

   localparam logic signed [65:0] SAT_MAX = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] SAT_MIN = -SAT_MAX - 66'sd1;
   localparam logic signed [COORD_WIDTH-1:0] BOX_MAX = SAT_MAX[COORD_WIDTH-1:0];
   localparam logic signed [COORD_WIDTH-1:0] BOX_MIN = SAT_MIN[COORD_WIDTH-1:0];
   localparam logic signed [64:0] SUM_TOP = 65'sh0_7FFF_FFFF_FFFF_FFFF;

   logic en;

   // stage 1: products
   logic               v1_ff, last1_ff, bad1_ff;
   logic [POINTS-1:0]  m1_ff;
   logic signed [63:0] p_xx_ff [POINTS];
   logic signed [63:0] p_xy_ff [POINTS];
   logic signed [63:0] p_yx_ff [POINTS];
   logic signed [63:0] p_yy_ff [POINTS];
   logic signed [63:0] p_xx_in [POINTS];
   logic signed [63:0] p_xy_in [POINTS];
   logic signed [63:0] p_yx_in [POINTS];
   logic signed [63:0] p_yy_in [POINTS];

   // stage 2: exact sums, shifted down
   logic               v2_ff, last2_ff, bad2_ff;
   logic [POINTS-1:0]  m2_ff;
   logic signed [64:0] s_x_ff [POINTS];
   logic signed [64:0] s_y_ff [POINTS];
   logic signed [64:0] s_x_in [POINTS];
   logic signed [64:0] s_y_in [POINTS];

   // stage 3: offset and saturation
   logic                         v3_ff, last3_ff, bad3_ff;
   logic [POINTS-1:0]            m3_ff;
   logic signed [COORD_WIDTH-1:0] t_x_ff [POINTS];
   logic signed [COORD_WIDTH-1:0] t_y_ff [POINTS];
   logic signed [COORD_WIDTH-1:0] t_x_in [POINTS];
   logic signed [COORD_WIDTH-1:0] t_y_in [POINTS];

   // stage 4: per-segment extremes
   logic                          v4_ff, last4_ff, bad4_ff, any4_ff, any4_in;
   logic signed [COORD_WIDTH-1:0] lo_x4_ff, lo_x4_in, lo_y4_ff, lo_y4_in;
   logic signed [COORD_WIDTH-1:0] hi_x4_ff, hi_x4_in, hi_y4_ff, hi_y4_in;

   // stage 5: running box
   logic                          has_ff, has_in;
   logic signed [COORD_WIDTH-1:0] low_x_ff, low_x_in, low_y_ff, low_y_in;
   logic signed [COORD_WIDTH-1:0] high_x_ff, high_x_in, high_y_ff, high_y_in;
   logic signed [63:0]            e_lo_x, e_lo_y, e_hi_x, e_hi_y;

   logic                          rsp_valid_ff;
   logic signed [31:0]            min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic                          box_valid_ff, status_ff;

   function automatic logic signed [COORD_WIDTH-1:0] saturate(input logic signed [65:0] v);
      if (v > SAT_MAX) begin
         return BOX_MAX;
      end
      if (v < SAT_MIN) begin
         return BOX_MIN;
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   assign en       = !(rsp_valid_ff && rsp_stall);
   assign in_ready = en;

   always_comb begin
      for (int i = 0; i < POINTS; i++) begin
         p_xx_in[i] = mtx.sxx * $signed(in_seg.px[i]);
         p_xy_in[i] = mtx.sxy * $signed(in_seg.py[i]);
         p_yx_in[i] = mtx.syx * $signed(in_seg.px[i]);
         p_yy_in[i] = mtx.syy * $signed(in_seg.py[i]);
         s_x_in[i]  = (65'(p_xx_ff[i]) + 65'(p_xy_ff[i])) >>> FRACTION_BITS;
         s_y_in[i]  = (65'(p_yx_ff[i]) + 65'(p_yy_ff[i])) >>> FRACTION_BITS;
         // with no fraction bits two full-scale products pin to the largest
         // 64-bit value before the offset goes on
         if (FRACTION_BITS == 0) begin
            if (s_x_in[i] > SUM_TOP) s_x_in[i] = SUM_TOP;
            if (s_y_in[i] > SUM_TOP) s_y_in[i] = SUM_TOP;
         end
         t_x_in[i]  = saturate(66'(s_x_ff[i]) + 66'(mtx.ox));
         t_y_in[i]  = saturate(66'(s_y_ff[i]) + 66'(mtx.oy));
      end
   end

   always_comb begin
      lo_x4_in = BOX_MAX;
      lo_y4_in = BOX_MAX;
      hi_x4_in = BOX_MIN;
      hi_y4_in = BOX_MIN;
      for (int i = 0; i < POINTS; i++) begin
         if (m3_ff[i]) begin
            if (t_x_ff[i] < lo_x4_in) lo_x4_in = t_x_ff[i];
            if (t_y_ff[i] < lo_y4_in) lo_y4_in = t_y_ff[i];
            if (t_x_ff[i] > hi_x4_in) hi_x4_in = t_x_ff[i];
            if (t_y_ff[i] > hi_y4_in) hi_y4_in = t_y_ff[i];
         end
      end
      any4_in = |m3_ff;
   end

   always_comb begin
      low_x_in  = (lo_x4_ff < low_x_ff)  ? lo_x4_ff : low_x_ff;
      low_y_in  = (lo_y4_ff < low_y_ff)  ? lo_y4_ff : low_y_ff;
      high_x_in = (hi_x4_ff > high_x_ff) ? hi_x4_ff : high_x_ff;
      high_y_in = (hi_y4_ff > high_y_ff) ? hi_y4_ff : high_y_ff;
      has_in    = has_ff || any4_ff;
      e_lo_x    = 64'(low_x_in);
      e_lo_y    = 64'(low_y_in);
      e_hi_x    = 64'(high_x_in);
      e_hi_y    = 64'(high_y_in);
   end

   // control: valid bits, running box, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         has_ff       <= 1'b0;
         low_x_ff     <= BOX_MAX;
         low_y_ff     <= BOX_MAX;
         high_x_ff    <= BOX_MIN;
         high_y_ff    <= BOX_MIN;
      end else if (en) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff && last4_ff;
         if (v4_ff) begin
            if (last4_ff) begin
               has_ff    <= 1'b0;
               low_x_ff  <= BOX_MAX;
               low_y_ff  <= BOX_MAX;
               high_x_ff <= BOX_MIN;
               high_y_ff <= BOX_MIN;
            end else begin
               has_ff    <= has_in;
               low_x_ff  <= low_x_in;
               low_y_ff  <= low_y_in;
               high_x_ff <= high_x_in;
               high_y_ff <= high_y_in;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         last1_ff <= in_seg.last;
         bad1_ff  <= in_seg.bad;
         m1_ff    <= in_seg.mask;
         last2_ff <= last1_ff;
         bad2_ff  <= bad1_ff;
         m2_ff    <= m1_ff;
         last3_ff <= last2_ff;
         bad3_ff  <= bad2_ff;
         m3_ff    <= m2_ff;
         last4_ff <= last3_ff;
         bad4_ff  <= bad3_ff;
         any4_ff  <= any4_in;
         lo_x4_ff <= lo_x4_in;
         lo_y4_ff <= lo_y4_in;
         hi_x4_ff <= hi_x4_in;
         hi_y4_ff <= hi_y4_in;
         for (int i = 0; i < POINTS; i++) begin
            p_xx_ff[i] <= p_xx_in[i];
            p_xy_ff[i] <= p_xy_in[i];
            p_yx_ff[i] <= p_yx_in[i];
            p_yy_ff[i] <= p_yy_in[i];
            s_x_ff[i]  <= s_x_in[i];
            s_y_ff[i]  <= s_y_in[i];
            t_x_ff[i]  <= t_x_in[i];
            t_y_ff[i]  <= t_y_in[i];
         end
         if (v4_ff && last4_ff) begin
            status_ff <= bad4_ff;
            if (bad4_ff || !has_in) begin
               min_x_ff     <= '0;
               min_y_ff     <= '0;
               max_x_ff     <= '0;
               max_y_ff     <= '0;
               box_valid_ff <= 1'b0;
            end else begin
               min_x_ff     <= e_lo_x[31:0];
               min_y_ff     <= e_lo_y[31:0];
               max_x_ff     <= e_hi_x[31:0];
               max_y_ff     <= e_hi_y[31:0];
               box_valid_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_box_min_x = min_x_ff;
   assign rsp_box_min_y = min_y_ff;
   assign rsp_box_max_x = max_x_ff;
   assign rsp_box_max_y = max_y_ff;
   assign rsp_box_valid = box_valid_ff;
   assign rsp_status    = status_ff;

endmodule

FILE: rtl/vector_path_bounding_box_core.sv
// Top level of the vector path bounding box: configuration registers, front, queue and back.
`timescale 1ns / 1ps

// Control-point bounding box of a vector path. Each request carries one path
// segment (command byte, bit 0 relative, and up to six Q16.16 coordinates);
// the front keeps the current point and subpath start, resolves relative,
// horizontal and vertical points (arcs give their end point only) and pushes
// up to three points per request into a four-entry queue. The back maps each
// point through the 2x3 affine matrix (products shifted down by FRACTION_BITS,
// offset added, saturated to COORD_WIDTH bits) and widens a min/max box.
// A request flagged end_of_path yields one response with the box, a valid
// flag and a status; a command index of 13 or more sets status and empties the
// box, and all path state then returns to its reset value. The block accepts
// one request per clock while the queue has room: the current-point update in
// the front is one saturating add per coordinate, and the back runs twelve
// 32x32 multipliers in parallel behind a five-register pipeline. The final
// segment of a path runs through the queue and those registers to the response;
// while it waits on rsp_stall the queue takes requests until its four entries fill.
// Write the matrix over the csr_ port only while no path is in flight.

module vector_path_bounding_box_core import vpbb_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // requests
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_op,
   input  logic signed [31:0]     req_coord_a,
   input  logic signed [31:0]     req_coord_b,
   input  logic signed [31:0]     req_coord_c,
   input  logic signed [31:0]     req_coord_d,
   input  logic signed [31:0]     req_coord_e,
   input  logic signed [31:0]     req_coord_f,
   input  logic                   req_end_of_path,
   // responses
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_box_min_x,
   output logic signed [31:0]     rsp_box_min_y,
   output logic signed [31:0]     rsp_box_max_x,
   output logic signed [31:0]     rsp_box_max_y,
   output logic                   rsp_box_valid,
   output logic                   rsp_status,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   matrix_type mtx_ff;
   logic       accept;
   logic       q_push_ready, q_pop_valid, back_ready;
   seg_type    front_seg, head_seg;

   // Take a configuration write in any cycle; indexes past the list drop.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtx_ff.sxx <= MATRIX_ONE;
         mtx_ff.sxy <= '0;
         mtx_ff.ox  <= '0;
         mtx_ff.syx <= '0;
         mtx_ff.syy <= MATRIX_ONE;
         mtx_ff.oy  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCALE_X_FROM_X: mtx_ff.sxx <= csr_data;
            CSR_SHEAR_X_FROM_Y: mtx_ff.sxy <= csr_data;
            CSR_OFFSET_X:       mtx_ff.ox  <= csr_data;
            CSR_SHEAR_Y_FROM_X: mtx_ff.syx <= csr_data;
            CSR_SCALE_Y_FROM_Y: mtx_ff.syy <= csr_data;
            CSR_OFFSET_Y:       mtx_ff.oy  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Hold requests off only when the queue is full.
   assign req_stall = !q_push_ready;
   assign accept    = req_valid && !req_stall;

   vpbb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .coord_a     (req_coord_a),
      .coord_b     (req_coord_b),
      .coord_c     (req_coord_c),
      .coord_d     (req_coord_d),
      .coord_e     (req_coord_e),
      .coord_f     (req_coord_f),
      .end_of_path (req_end_of_path),
      .seg         (front_seg)
   );

   vpbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_seg   (front_seg),
      .push_ready (q_push_ready),
      .pop_ready  (back_ready),
      .pop_valid  (q_pop_valid),
      .head       (head_seg)
   );

   vpbb_back #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .mtx           (mtx_ff),
      .in_valid      (q_pop_valid),
      .in_seg        (head_seg),
      .in_ready      (back_ready),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_box_min_x (rsp_box_min_x),
      .rsp_box_min_y (rsp_box_min_y),
      .rsp_box_max_x (rsp_box_max_x),
      .rsp_box_max_y (rsp_box_max_y),
      .rsp_box_valid (rsp_box_valid),
      .rsp_status    (rsp_status)
   );

endmodule

FILE: rtl/vpbb_checker.sv
// Port-level checker for the vector path bounding box, bound to the top level.
`timescale 1ns / 1ps

module vpbb_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_box_min_x,
   input logic signed [31:0] rsp_box_min_y,
   input logic signed [31:0] rsp_box_max_x,
   input logic signed [31:0] rsp_box_max_y,
   input logic               rsp_box_valid,
   input logic               rsp_status
);

   // no response straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_box_min_x)
         && $stable(rsp_box_min_y) && $stable(rsp_box_max_x)
         && $stable(rsp_box_max_y) && $stable(rsp_box_valid) && $stable(rsp_status))
      else $error("stalled response changed");

   // an empty or failed box reads as zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_valid |-> rsp_box_min_x == 0 && rsp_box_min_y == 0
         && rsp_box_max_x == 0 && rsp_box_max_y == 0)
      else $error("empty box with nonzero fields");

   // an unknown command never gives a valid box
   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_box_valid)
      else $error("valid box together with error status");

endmodule

bind vector_path_bounding_box_core vpbb_checker u_checker (.*);

FILE: sim/tb_vector_path_bounding_box_core.sv
// Self-checking testbench of the vector path bounding box core: box tracker, drivers and checks.
`timescale 1ns / 1ps

module tb_vector_path_bounding_box_core;
   import vpbb_pkg::*;

   localparam int COORD_W         = 32;
   localparam int FRAC_BITS       = 16;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 75;
   // give the box ample room to leave after the final request
   localparam int SETTLE_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT  = 2000;

   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

   // arc commands keep their end point only
   localparam logic [6:0] CMD_ARC_SCCW = 7'd9;
   localparam logic [6:0] CMD_ARC_SCW  = 7'd10;
   localparam logic [6:0] CMD_ARC_LCCW = 7'd11;
   localparam logic [6:0] CMD_ARC_LCW  = 7'd12;
   localparam logic [6:0] CMD_TOP      = 7'd127;

   // saturation bounds of a transformed coordinate
   localparam logic signed [95:0] CW_MAX = (96'sd1 <<< (COORD_W - 1)) - 96'sd1;
   localparam logic signed [95:0] CW_MIN = -CW_MAX - 96'sd1;

   typedef enum int {
      MTX_RESET, MTX_IDENTITY, MTX_ALL_MAX, MTX_ALL_MIN, MTX_ZERO, MTX_RANDOM
   } matrix_setup;

   typedef struct packed {
      logic [31:0] min_x;
      logic [31:0] min_y;
      logic [31:0] max_x;
      logic [31:0] max_y;
      logic        box_ok;
      logic        status;
   } box_result;

   // Tracks the path as the block should: current point, subpath start,
   // running box and error flag. Holds the boxes still owed by the block.
   class box_tracker;
      matrix_type         mtx;
      logic signed [31:0] cur_x, cur_y, sub_x, sub_y;
      logic signed [63:0] lo_x, lo_y, hi_x, hi_y;
      bit                 seen, bad;
      box_result          boxes_due[$];
      int                 mismatches;
      int                 boxes_checked;

      function new();
         mtx = '{sxx: MATRIX_ONE, sxy: 32'sd0, ox: 32'sd0,
                 syx: 32'sd0, syy: MATRIX_ONE, oy: 32'sd0};
         mismatches    = 0;
         boxes_checked = 0;
         clear_path();
      endfunction

      function void clear_path();
         cur_x = '0;
         cur_y = '0;
         sub_x = '0;
         sub_y = '0;
         lo_x  = CW_MAX[63:0];
         lo_y  = CW_MAX[63:0];
         hi_x  = CW_MIN[63:0];
         hi_y  = CW_MIN[63:0];
         seen  = 1'b0;
         bad   = 1'b0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_SCALE_X_FROM_X: mtx.sxx = data;
            CSR_SHEAR_X_FROM_Y: mtx.sxy = data;
            CSR_OFFSET_X:       mtx.ox  = data;
            CSR_SHEAR_Y_FROM_X: mtx.syx = data;
            CSR_SCALE_Y_FROM_Y: mtx.syy = data;
            CSR_OFFSET_Y:       mtx.oy  = data;
            default: ;
         endcase
      endfunction

      // exact sum of products, floor shift, offset, then saturate
      function logic signed [63:0] map_axis(logic signed [31:0] m0, m1, off, x, y);
         logic signed [95:0] a0, a1, vx, vy, acc;
         a0  = m0;
         a1  = m1;
         vx  = x;
         vy  = y;
         acc = ((a0 * vx + a1 * vy) >>> FRAC_BITS) + off;
         if (acc > CW_MAX) acc = CW_MAX;
         if (acc < CW_MIN) acc = CW_MIN;
         return acc[63:0];
      endfunction

      function logic signed [31:0] clamp_point(logic signed [33:0] v);
         if (v > 34'sh0_7FFF_FFFF) return MAX32;
         if (v < -34'sh0_8000_0000) return MIN32;
         return v[31:0];
      endfunction

      function void widen(logic signed [31:0] x, y);
         logic signed [63:0] tx, ty;
         tx = map_axis(mtx.sxx, mtx.sxy, mtx.ox, x, y);
         ty = map_axis(mtx.syx, mtx.syy, mtx.oy, x, y);
         if (tx < lo_x) lo_x = tx;
         if (tx > hi_x) hi_x = tx;
         if (ty < lo_y) lo_y = ty;
         if (ty > hi_y) hi_y = ty;
         seen = 1'b1;
      endfunction

      function void take_segment(logic [7:0] op, logic signed [31:0] a, b, c, d, e, f,
                                 bit last);
         logic [6:0]         kind;
         bit                 rel;
         logic signed [33:0] px [3];
         logic signed [33:0] py [3];
         int                 n, i;
         box_result          res;
         kind = op[7:1];
         rel  = op[0];
         n    = 0;
         if (!bad) begin
            if (kind >= CMD_LIMIT) begin
               bad = 1'b1;
            end else begin
               case (kind)
                  CMD_CLOSE: begin
                     cur_x = sub_x;
                     cur_y = sub_y;
                  end
                  CMD_MOVE, CMD_LINE, CMD_SQUAD: begin
                     px[0] = a; py[0] = b; n = 1;
                  end
                  CMD_HLINE: begin
                     px[0] = a;
                     if (rel) px[0] += cur_x;
                     py[0] = cur_y; n = 1; rel = 1'b0;
                  end
                  CMD_VLINE: begin
                     px[0] = cur_x;
                     py[0] = a;
                     if (rel) py[0] += cur_y;
                     n = 1; rel = 1'b0;
                  end
                  CMD_QUAD, CMD_SCUBIC: begin
                     px[0] = a; py[0] = b; px[1] = c; py[1] = d; n = 2;
                  end
                  CMD_CUBIC: begin
                     px[0] = a; py[0] = b; px[1] = c; py[1] = d;
                     px[2] = e; py[2] = f; n = 3;
                  end
                  default: begin
                     // arcs: end point only
                     px[0] = d; py[0] = e; n = 1;
                  end
               endcase
               for (i = 0; i < n; i++) begin
                  // every point of a segment is relative to its starting point
                  if (rel) begin
                     px[i] += cur_x;
                     py[i] += cur_y;
                  end
                  px[i] = clamp_point(px[i]);
                  py[i] = clamp_point(py[i]);
                  widen(px[i][31:0], py[i][31:0]);
               end
               if (n > 0) begin
                  cur_x = px[n-1][31:0];
                  cur_y = py[n-1][31:0];
                  if (kind == CMD_MOVE) begin
                     sub_x = cur_x;
                     sub_y = cur_y;
                  end
               end
            end
         end
         if (last) begin
            res = '0;
            if (!bad && seen) begin
               res.min_x  = lo_x[31:0];
               res.min_y  = lo_y[31:0];
               res.max_x  = hi_x[31:0];
               res.max_y  = hi_y[31:0];
               res.box_ok = 1'b1;
            end
            res.status = bad;
            boxes_due = {boxes_due, res};
            clear_path();
         end
      endfunction

      task report_mismatch(string what);
         $display("[%0t] box %0d: %s", $realtime, boxes_checked, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
      endtask

      task check_box(box_result got);
         box_result want;
         if (boxes_due.size() == 0) begin
            report_mismatch("response with no path pending");
         end else begin
            want = boxes_due.pop_front();
            compare_field("box_min_x", got.min_x, want.min_x);
            compare_field("box_min_y", got.min_y, want.min_y);
            compare_field("box_max_x", got.max_x, want.max_x);
            compare_field("box_max_y", got.max_y, want.max_y);
            compare_field("box_valid", got.box_ok, want.box_ok);
            compare_field("status", got.status, want.status);
         end
         boxes_checked++;
      endtask
   endclass

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_op          = '0;
   logic signed [31:0]     req_coord_a     = '0;
   logic signed [31:0]     req_coord_b     = '0;
   logic signed [31:0]     req_coord_c     = '0;
   logic signed [31:0]     req_coord_d     = '0;
   logic signed [31:0]     req_coord_e     = '0;
   logic signed [31:0]     req_coord_f     = '0;
   logic                   req_end_of_path = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic signed [31:0]     rsp_box_min_x;
   logic signed [31:0]     rsp_box_min_y;
   logic signed [31:0]     rsp_box_max_x;
   logic signed [31:0]     rsp_box_max_y;
   logic                   rsp_box_valid;
   logic                   rsp_status;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [31:0]            csr_data        = '0;

   box_tracker sb;
   bit         req_calm = 1'b0;

   vector_path_bounding_box_core #(
      .COORD_WIDTH   (COORD_W),
      .FRACTION_BITS (FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_coord_a     (req_coord_a),
      .req_coord_b     (req_coord_b),
      .req_coord_c     (req_coord_c),
      .req_coord_d     (req_coord_d),
      .req_coord_e     (req_coord_e),
      .req_coord_f     (req_coord_f),
      .req_end_of_path (req_end_of_path),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_box_min_x   (rsp_box_min_x),
      .rsp_box_min_y   (rsp_box_min_y),
      .rsp_box_max_x   (rsp_box_max_x),
      .rsp_box_max_y   (rsp_box_max_y),
      .rsp_box_valid   (rsp_box_valid),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] op_code(logic [6:0] kind, bit rel);
      return {kind, rel};
   endfunction

   // mostly moderate values, with a good share of the extremes and raw noise
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return MAX32;
         1:       return MIN32;
         2, 3:    return $urandom;
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic logic [31:0] matrix_entry(matrix_setup setup, bit diagonal);
      case (setup)
         MTX_IDENTITY: return diagonal ? MATRIX_ONE : 32'd0;
         MTX_ALL_MAX:  return MAX32;
         MTX_ALL_MIN:  return MIN32;
         MTX_ZERO:     return 32'd0;
         default: begin
            case ($urandom_range(0, 3))
               0:       return $urandom;
               1:       return diagonal ? MATRIX_ONE : 32'd0;
               default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            endcase
         end
      endcase
   endfunction

   // Offer one request after a random gap, hold it until the block takes it,
   // then note it in the tracker. Valid is only lowered when a gap follows.
   task automatic send_segment(input logic [7:0] op,
                               input logic signed [31:0] a, b, c, d, e, f,
                               input bit last);
      int gap;
      if ($urandom_range(0, 15) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op          <= op;
      req_coord_a     <= a;
      req_coord_b     <= b;
      req_coord_c     <= c;
      req_coord_d     <= d;
      req_coord_e     <= e;
      req_coord_f     <= f;
      req_end_of_path <= last;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_segment(op, a, b, c, d, e, f, last);
   endtask

   // Most paths open with a move and carry legal commands; a tenth get a
   // bad command dropped in and a tenth start from a raw command byte.
   task automatic send_random_path(output int len);
      int         i, flavour;
      logic [7:0] op;
      len     = $urandom_range(1, 10);
      flavour = $urandom_range(0, 9);
      for (i = 0; i < len; i++) begin
         if (i == 0 && flavour == 1)
            op = 8'($urandom_range(0, 255));
         else if (i == 0 && flavour != 2)
            op = op_code(CMD_MOVE, 1'($urandom_range(0, 1)));
         else if (flavour == 0 && $urandom_range(0, len) == 0)
            op = op_code(7'($urandom_range(CMD_LIMIT, CMD_TOP)), 1'($urandom_range(0, 1)));
         else
            op = op_code(7'($urandom_range(CMD_CLOSE, CMD_ARC_LCW)),
                         1'($urandom_range(0, 1)));
         send_segment(op, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_register(idx, data);
   endtask

   // back-to-back writes keep valid high; drop it after the last one
   task automatic load_matrix(input matrix_setup setup);
      write_register(CSR_SCALE_X_FROM_X, matrix_entry(setup, 1'b1));
      write_register(CSR_SHEAR_X_FROM_Y, matrix_entry(setup, 1'b0));
      write_register(CSR_OFFSET_X,       matrix_entry(setup, 1'b0));
      write_register(CSR_SHEAR_Y_FROM_X, matrix_entry(setup, 1'b0));
      write_register(CSR_SCALE_Y_FROM_Y, matrix_entry(setup, 1'b1));
      write_register(CSR_OFFSET_Y,       matrix_entry(setup, 1'b0));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every owed box, then let the pipeline run empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.boxes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: stall for a random count before each box, with calm
   // stretches, and check every box taken against the oldest one owed.
   initial begin : response_side
      int        gap;
      bit        calm;
      box_result got;
      calm = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.min_x  = rsp_box_min_x;
         got.min_y  = rsp_box_min_y;
         got.max_x  = rsp_box_max_x;
         got.max_y  = rsp_box_max_y;
         got.box_ok = rsp_box_valid;
         got.status = rsp_status;
         sb.check_box(got);
         @(negedge clock);
      end
   end

   // End the run once no handshake of any kind has happened for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      matrix_setup setup;
      int          sent, len, p;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         setup = (p < MTX_RANDOM) ? matrix_setup'(p) : MTX_RANDOM;
         if (setup != MTX_RESET) begin
            load_matrix(setup);
         end else begin
            // Directed paths under the reset matrix. First every command,
            // some absolute and some relative, with relative sums driven past both
            // ends of the coordinate range, then a close and a relative
            // line from the subpath start.
            send_segment(op_code(CMD_MOVE, 0), MIN32, MAX32, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_LINE, 1), MIN32, MIN32, 5, 6, 7, 8, 0);
            send_segment(op_code(CMD_HLINE, 1), MAX32, MIN32, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_VLINE, 1), MIN32, MAX32, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_HLINE, 0), 32'sh1234_5678, 0, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_VLINE, 0), MAX32, 0, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_QUAD, 1), 32'sh0001_0000, -32'sh0002_0000,
                         32'sh0003_0000, -32'sh0004_0000, MAX32, MIN32, 0);
            send_segment(op_code(CMD_CUBIC, 0), -32'sh0010_0000, 32'sh0020_0000,
                         32'sh0030_0000, -32'sh0040_0000, 32'sh0050_0000,
                         32'sh0060_0000, 0);
            send_segment(op_code(CMD_SQUAD, 1), -32'sh0000_8000, 32'sh0000_8000,
                         0, 0, 0, 0, 0);
            send_segment(op_code(CMD_SCUBIC, 0), 32'sh0100_0000, 32'sh0200_0000,
                         -32'sh0300_0000, -32'sh0400_0000, 0, 0, 0);
            send_segment(op_code(CMD_ARC_SCCW, 0), MAX32, MAX32, MAX32,
                         32'sh0007_0000, -32'sh0007_0000, MIN32, 0);
            send_segment(op_code(CMD_ARC_SCW, 1), MIN32, MIN32, MIN32,
                         32'sh0000_0100, 32'sh0000_0200, MAX32, 0);
            send_segment(op_code(CMD_ARC_LCCW, 0), 0, 0, 0, MIN32, MAX32, 0, 0);
            send_segment(op_code(CMD_ARC_LCW, 1), 0, 0, 0, MAX32, MAX32, 0, 0);
            send_segment(op_code(CMD_CLOSE, 0), MAX32, MAX32, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_LINE, 1), MAX32, MAX32, 0, 0, 0, 0, 1);
            // a path with no point gives an empty box
            send_segment(op_code(CMD_CLOSE, 1), 0, 0, 0, 0, 0, 0, 1);
            // an unknown command freezes the path and empties the box
            send_segment(op_code(CMD_MOVE, 0), 32'sh0001_0000, 32'sh0001_0000,
                         0, 0, 0, 0, 0);
            send_segment(op_code(CMD_LIMIT, 1), 0, 0, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_LINE, 0), MAX32, MIN32, 0, 0, 0, 0, 1);
            send_segment(op_code(CMD_TOP, 1), MIN32, MAX32, MIN32, MAX32, MIN32, MAX32, 1);
            // positive overflow of relative points, then a vertical line
            // that starts from the origin
            send_segment(op_code(CMD_LINE, 1), MAX32, MAX32, 0, 0, 0, 0, 0);
            send_segment(op_code(CMD_LINE, 1), MAX32, MAX32, 0, 0, 0, 0, 1);
            send_segment(op_code(CMD_VLINE, 1), -32'sh0000_0001, 0, 0, 0, 0, 0, 1);
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_random_path(len);
            sent += len;
         end
         // the matrix may only change once the block holds no path
         settle();
      end

      if (sb.mismatches == 0 && sb.boxes_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
